### design/aes128_keystream_xor_macros.svh
// Assertion macros shared by the block's modules.
`ifndef AES128_KEYSTREAM_XOR_MACROS_SVH
`define AES128_KEYSTREAM_XOR_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AKX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must be at most one-hot outside reset.
`define AKX_ONEHOT0(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sig)) else $error(msg);

`endif

### design/akx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akx_pkg: shared types, constants and functions
// S-box, GF doubling and op codes for the keystream block.
// ----------------------------------------------------------------------------
package akx_pkg;

  localparam int unsigned DefaultRounds = 10;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [4:0] key_index;
    logic [63:0] key_word;
    logic [63:0] iv_hi;
    logic [63:0] iv_lo;
    logic [63:0] text_hi;
    logic [63:0] text_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } out_item_t;

  // Lane control from the sequencer.
  typedef struct packed {
    logic load;   // take the counter block plus round key 0
    logic step;   // apply one round plus its key
    logic last;   // final round: skip column mixing
  } lane_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### design/akx_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akx_stream_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface akx_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/akx_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akx_lane: one AES state column
// Holds one 32-bit column; loads the counter column plus key, or applies
// SubBytes on the shifted bytes, MixColumns unless last, and the round key column.
// ----------------------------------------------------------------------------
module akx_lane (
  input  logic               clk_i,
  input  akx_pkg::lane_ctl_t ctl_i,
  input  logic [31:0]        shifted_i,  // bytes after row shift, row 0 on top
  input  logic [31:0]        init_i,     // counter column for load
  input  logic [31:0]        key_i,      // round key column
  output logic [31:0]        col_o
);
  logic [31:0] col_q, col_d;
  logic [7:0]  a [4];
  logic [7:0]  d [4];
  logic [31:0] mix;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      a[r] = akx_pkg::sbox(shifted_i[31-8*r -: 8]);
      d[r] = akx_pkg::gf_double(a[r]);
    end
    mix = {d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3],
           a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3],
           a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3],
           d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3]};
    col_d = col_q;
    if (ctl_i.load) begin
      col_d = init_i ^ key_i;
    end else if (ctl_i.step) begin
      col_d = (ctl_i.last ? {a[0], a[1], a[2], a[3]} : mix) ^ key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o = col_q;
endmodule

### design/akx_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akx_merge: lane merge and output register
// Joins the four columns, XORs the data block and holds the result.
// ----------------------------------------------------------------------------
module akx_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                done_i,
  input  logic [127:0]        state_i,
  input  logic [127:0]        text_i,
  output logic                busy_o,
  akx_stream_if.source        out_if
);
  logic         valid_q;
  logic [127:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (done_i) begin
      valid_q <= 1'b1;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_i) begin
      data_q <= state_i ^ text_i;
    end
  end

  assign out_if.valid       = valid_q;
  assign out_if.data.out_hi = data_q[127:64];
  assign out_if.data.out_lo = data_q[63:0];
  assign busy_o             = valid_q;
endmodule

### design/aes128_keystream_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_keystream_xor: AES counter-mode block step
// Encrypts a counter block with a loaded expanded key and XORs it onto data.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_if   | in  | op, key_index, key_word, iv_hi/lo, text_hi/lo
// out_if  | out | out_hi, out_lo (encrypt only)
//
// A key load gives no result. An encrypt runs the initial key add and the
// rounds in four column lanes sharing one round step per cycle, bound by
// one round-key read from the key store. The output register loads from
// the lanes once the registered done flag is set. The result waits in the
// output register; the next item is accepted once the previous result
// has transferred. Reset clears only control state; the key store is
// undefined until written.
// ----------------------------------------------------------------------------
`include "aes128_keystream_xor_macros.svh"

module aes128_keystream_xor #(
  parameter int unsigned ROUNDS = akx_pkg::DefaultRounds
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  akx_stream_if.sink   in_if,
  akx_stream_if.source out_if
);
  localparam int unsigned KeyWords = 2 * (ROUNDS + 1);
  localparam int unsigned RW       = $clog2(ROUNDS + 1);

  // Key store: two words per round key, read as a 128-bit row.
  logic [127:0] key_mem [ROUNDS + 1];
  logic [127:0] rkey_q;

  logic         busy_q;
  logic [RW-1:0] rnd_q;
  logic [127:0] text_q;
  logic [127:0] iv_q;
  logic         first_q;
  logic         done_q;
  logic         out_busy;
  logic         done;
  logic [127:0] state;
  logic [127:0] shifted;
  akx_pkg::lane_ctl_t ctl;
  logic         acc;
  logic [RW-1:0] rd_idx;

  // Hold off input while the lanes run and until the result register is free.
  assign in_if.ready = !busy_q && !done_q && !out_busy;
  assign acc = in_if.valid && in_if.ready;

  // Write one 64-bit half; drop out-of-range indices.
  always_ff @(posedge clk_i) begin
    if (acc && in_if.data.op == akx_pkg::OP_LOAD
        && {27'd0, in_if.data.key_index} < KeyWords) begin
      if (in_if.data.key_index[0]) begin
        key_mem[in_if.data.key_index[4:1]][63:0]   <= in_if.data.key_word;
      end else begin
        key_mem[in_if.data.key_index[4:1]][127:64] <= in_if.data.key_word;
      end
    end
  end

  // Read the round key needed by the next cycle: key 1 during the initial
  // add, key rnd_q+2 during a round step, key 0 otherwise (ready for accept).
  always_comb begin
    if (first_q) begin
      rd_idx = RW'(1);
    end else if (ctl.step && !ctl.last) begin
      rd_idx = RW'(rnd_q + 2'd2);
    end else begin
      rd_idx = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_q <= key_mem[rd_idx];
  end

  // Sequencer: first_q marks key 0 arriving; rnd_q counts rounds done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      rnd_q   <= '0;
    end else begin
      first_q <= 1'b0;
      done_q  <= done;
      if (acc && in_if.data.op == akx_pkg::OP_ENCRYPT) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        rnd_q   <= '0;
      end else if (busy_q && !first_q) begin
        rnd_q <= RW'(rnd_q + 1'b1);
        if (done) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      iv_q   <= {in_if.data.iv_hi, in_if.data.iv_lo};
      text_q <= {in_if.data.text_hi, in_if.data.text_lo};
    end
  end

  // rnd_q+1 is the round applied this cycle.
  assign ctl.load = first_q;
  assign ctl.step = busy_q && !first_q;
  assign ctl.last = (rnd_q == RW'(ROUNDS - 1));
  assign done     = ctl.step && ctl.last;

  // Row shift: row r of column c takes column c+r.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127-32*c-8*r -: 8] = state[127-32*((c+r)%4)-8*r -: 8];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    akx_lane u_lane (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .shifted_i(shifted[127-32*g -: 32]),
      .init_i   (iv_q[127-32*g -: 32]),
      .key_i    (rkey_q[127-32*g -: 32]),
      .col_o    (state[127-32*g -: 32])
    );
  end

  // The lanes hold the final state in the cycle after the last step; merge then.
  akx_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .done_i (done_q),
    .state_i(state),
    .text_i (text_q),
    .busy_o (out_busy),
    .out_if (out_if)
  );

  `AKX_ASSERT(a_no_accept_busy, clk_i, rst_ni, busy_q |-> !in_if.ready, "accept while busy")
  `AKX_ASSERT(a_done_busy, clk_i, rst_ni, done |-> busy_q, "done while idle")
  `AKX_ASSERT(a_out_after_done, clk_i, rst_ni, $rose(out_if.valid) |-> $past(done_q), "result without done")
endmodule

### tb/aes_ctr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctr_checker: keystream predictor and result comparison
// Watches both channels, keeps its own copy of the expanded key store,
// computes the expected XOR of data and encrypted counter for every encrypt
// transfer, and compares each result transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module aes_ctr_checker
  import akx_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  akx_stream_if in_ch,
  akx_stream_if out_ch,
  output int    mismatches_o,
  output int    pending_o
);

  localparam int unsigned KeyWords = 2 * (DefaultRounds + 1);

  localparam logic [7:0] SubTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [63:0] key_words [KeyWords];
  out_item_t   expected_q [$];

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Encrypt the counter block with the current key store.
  function automatic logic [127:0] encrypt_counter(logic [127:0] ctr);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] rk;
    for (int i = 0; i < 16; i++) s[i] = ctr[127 - 8 * i -: 8];
    for (int r = 0; r <= DefaultRounds; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++)
            t[4 * c + w] = SubTab[s[4 * ((c + w) % 4) + w]];
        for (int c = 0; c < 4; c++) begin
          a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
          if (r == DefaultRounds) begin
            s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
          end else begin
            s[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            s[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            s[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            s[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
          end
        end
      end
      rk = {key_words[2 * r], key_words[2 * r + 1]};
      for (int i = 0; i < 16; i++) s[i] ^= rk[127 - 8 * i -: 8];
    end
    for (int i = 0; i < 16; i++) encrypt_counter[127 - 8 * i -: 8] = s[i];
  endfunction

  task automatic report(string field, logic [63:0] exp_v, logic [63:0] got_v);
    $display("[%0t] mismatch on %s: expected %h got %h", $realtime, field, exp_v, got_v);
    mismatches_o++;
  endtask

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    for (int i = 0; i < KeyWords; i++) key_words[i] = '0;
  end

  always @(posedge clk_i) begin
    in_item_t    it;
    out_item_t   ex;
    out_item_t   got;
    logic [127:0] ks;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        it = in_ch.data;
        if (it.op == OP_LOAD) begin
          // drop loads beyond the store depth
          if (it.key_index < KeyWords) key_words[it.key_index] = it.key_word;
        end else begin
          ks = encrypt_counter({it.iv_hi, it.iv_lo}) ^ {it.text_hi, it.text_lo};
          ex.out_hi = ks[127:64];
          ex.out_lo = ks[63:0];
          expected_q.push_back(ex);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_q.size() == 0) begin
          report("unexpected result out_hi", '0, got.out_hi);
        end else begin
          ex = expected_q.pop_front();
          if (got.out_hi !== ex.out_hi) report("out_hi", ex.out_hi, got.out_hi);
          if (got.out_lo !== ex.out_lo) report("out_lo", ex.out_lo, got.out_lo);
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: counter-mode keystream block regression
// Loads the full expanded key, runs directed encrypts on field extremes and
// ignored-load corner cases, then a long random mix of key rewrites and
// encrypts with random idling on both channels and one long output stall.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import akx_pkg::*;

  localparam int KeyWords   = 2 * (DefaultRounds + 1);
  localparam int RandItems  = 1680;
  localparam int StallLimit = 5000;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   pending;
  int   results_seen;
  int   items_sent;

  akx_stream_if #(.T(in_item_t))  in_if ();
  akx_stream_if #(.T(out_item_t)) out_if ();

  aes128_keystream_xor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  aes_ctr_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Random 64-bit value biased toward all-zero and all-one extremes.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one item and hold it until the transfer happens.
  task automatic send(in_item_t it);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!(in_if.valid && in_if.ready)) @(posedge clk_i);
    items_sent++;
  endtask

  // Idle the input now and then, except in the quiet stretch mid-run.
  task automatic maybe_idle();
    if (!(items_sent inside {[900:1150]}) && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t load_item(int idx, logic [63:0] word);
    in_item_t it;
    it           = '{default: '0};
    it.op        = OP_LOAD;
    it.key_index = idx[4:0];
    it.key_word  = word;
    it.iv_hi     = rand_word();
    it.iv_lo     = rand_word();
    it.text_hi   = rand_word();
    it.text_lo   = rand_word();
    return it;
  endfunction

  function automatic in_item_t enc_item(logic [63:0] ivh, logic [63:0] ivl,
                                        logic [63:0] th, logic [63:0] tl);
    in_item_t it;
    it           = '{default: '0};
    it.op        = OP_ENCRYPT;
    it.key_index = 5'($urandom_range(31));
    it.key_word  = rand_word();
    it.iv_hi     = ivh;
    it.iv_lo     = ivl;
    it.text_hi   = th;
    it.text_lo   = tl;
    return it;
  endfunction

  // Stimulus and verdict.
  initial begin
    items_sent  = 0;
    rst_ni      = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every key word before any encrypt; first and last words at extremes.
    for (int k = 0; k < KeyWords; k++)
      send(load_item(k, k == 0 ? '1 : (k == KeyWords - 1 ? '0 : rand_word())));
    // Loads past the store depth must leave the key untouched.
    send(load_item(KeyWords, '1));
    send(load_item(31, 64'h0123_4567_89ab_cdef));
    send(enc_item('0, '0, '0, '0));
    send(enc_item('1, '1, '1, '1));
    send(enc_item('0, '1, '1, '0));
    maybe_idle();

    for (int n = 0; n < RandItems; n++) begin
      if ($urandom_range(99) < 20)
        send(load_item($urandom_range(31), rand_word()));
      else
        send(enc_item(rand_word(), rand_word(), rand_word(), rand_word()));
      maybe_idle();
    end
    in_if.valid <= 1'b0;

    // Let the checker record the last transfer before draining.
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("aes128_keystream_xor regression: pass");
    else
      $display("aes128_keystream_xor regression: fail");
    $finish;
  end

  // Result side: random back-pressure, one long hold-off, one stall-free stretch.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    results_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) results_seen++;
      if (!hold_done && results_seen == 100) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (results_seen inside {[500:700]}) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 25);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("aes128_keystream_xor regression: fail");
        $finish;
      end
    end
  end

endmodule
